// ===== design/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants for the floppy sector controller.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int IdxW = 8;

  typedef enum logic [3:0] {
    CMD_CPU_RD   = 4'd0,
    CMD_CPU_WR   = 4'd1,
    CMD_CONTROL  = 4'd2,
    CMD_DETACH   = 4'd3,
    CMD_RESET    = 4'd4,
    CMD_NOP      = 4'd5,
    CMD_INT_ACK  = 4'd6,
    CMD_RD_DONE  = 4'd7,
    CMD_WR_DONE  = 4'd8,
    CMD_DRV_STORE = 4'd9,
    CMD_DRV_FETCH = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SECT_RD   = 3'd1,
    PH_BUF_RD    = 3'd2,
    PH_RD_CANCEL = 3'd3,
    PH_WR_START  = 3'd4,
    PH_WR_CANCEL = 3'd5,
    PH_BUF_WR    = 3'd6,
    PH_SECT_WR   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } disk_req_t;

  localparam logic [5:0] IRQ_HW_ERR   = 6'b001000;
  localparam logic [5:0] IRQ_DISK_END = 6'b010000;
  localparam logic [5:0] IRQ_READY    = 6'b100000;

  localparam logic [4:0] SPEC_TABLE [6] = '{5'b11010, 5'b01010, 5'b10010,
                                            5'b00010, 5'b00100, 5'b00001};

  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [IdxW-1:0] rd_addr;
    logic [IdxW-1:0] wr_addr;
    logic [7:0]      wr_data;
  } mem_req_t;

  typedef struct packed {
    logic            fill_start;
    logic [IdxW-1:0] fill_from;
  } fill_req_t;

  typedef struct packed {
    logic       reply;
    logic       rd;
    logic [4:0] int_spec;
    logic       irq_pending;
    logic [1:0] disk_request;
    logic [1:0] req_drive;
    logic [6:0] req_track;
    logic [4:0] req_sector;
  } result_t;

endpackage

// ===== design/fsc_in_if.sv =====
// ----------------------------------------------------------------------------
// fsc_in_if
// Event channel into the controller.
// ----------------------------------------------------------------------------
interface fsc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [15:0] data;
  logic [7:0]  drive_byte;
  logic [1:0]  ctl_kind;
  logic        transfer_ok;

  modport source (output valid, command, data, drive_byte, ctl_kind, transfer_ok,
                  input ready);
  modport sink (input valid, command, data, drive_byte, ctl_kind, transfer_ok,
                output ready);
endinterface

// ===== design/fsc_out_if.sv =====
// ----------------------------------------------------------------------------
// fsc_out_if
// Result channel out of the controller.
// ----------------------------------------------------------------------------
interface fsc_out_if;
  logic       valid;
  logic       ready;
  logic       reply;
  logic [7:0] read_byte;
  logic [4:0] int_spec;
  logic       irq_pending;
  logic [1:0] disk_request;
  logic [1:0] req_drive;
  logic [6:0] req_track;
  logic [4:0] req_sector;

  modport source (output valid, reply, read_byte, int_spec, irq_pending, disk_request,
                  req_drive, req_track, req_sector, input ready);
  modport sink (input valid, reply, read_byte, int_spec, irq_pending, disk_request,
                req_drive, req_track, req_sector, output ready);
endinterface

// ===== design/fsc_buffer.sv =====
// ----------------------------------------------------------------------------
// fsc_buffer
// Sector buffer memory with registered read and a zero-fill sweep.
// ----------------------------------------------------------------------------
module fsc_buffer
  import fsc_pkg::*;
#(
  parameter int SECTOR_BYTES = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  mem_req_t  mreq,
  input  fill_req_t freq,
  output logic [7:0] rdata,
  output logic      fill_busy
);

  localparam int AW = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
  localparam logic [IdxW:0] LastIdx = (IdxW+1)'(SECTOR_BYTES - 1);

  logic [7:0]      mem [SECTOR_BYTES];
  logic [IdxW-1:0] fill_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_busy <= 1'b0;
    end else if (freq.fill_start) begin
      fill_busy <= 1'b1;
    end else if (fill_busy && ({1'b0, fill_addr} == LastIdx)) begin
      fill_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (freq.fill_start) begin
      fill_addr <= freq.fill_from;
    end else if (fill_busy) begin
      fill_addr <= fill_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_busy) begin
      mem[fill_addr[AW-1:0]] <= 8'h00;
    end else if (mreq.wr_en) begin
      mem[mreq.wr_addr[AW-1:0]] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rdata <= mem[mreq.rd_addr[AW-1:0]];
    end
  end

endmodule

// ===== design/fsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsc_ctrl
// Phase machine, address and interrupt registers; one event per cycle while items are accepted.
// ----------------------------------------------------------------------------
module fsc_ctrl
  import fsc_pkg::*;
#(
  parameter int SECTORS_PER_TRACK = 26,
  parameter int LAST_TRACK        = 76,
  parameter int SECTOR_BYTES      = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        acc,
  input  logic [3:0]  command,
  input  logic [15:0] data,
  input  logic [7:0]  drive_byte,
  input  logic [1:0]  ctl_kind,
  input  logic        transfer_ok,
  output mem_req_t    mreq,
  output fill_req_t   freq,
  output result_t     res
);

  localparam logic [4:0]  Spt    = 5'(SECTORS_PER_TRACK);
  localparam logic [6:0]  LastT  = 7'(LAST_TRACK);
  localparam logic [IdxW:0]  SbIdx  = (IdxW+1)'(SECTOR_BYTES);
  localparam logic [15:0] SbData = 16'(SECTOR_BYTES);

  phase_t          phase, phase_next;
  logic [1:0]      drive_sel, drive_sel_next;
  logic            side_sel, side_sel_next;
  logic [6:0]      track_no, track_no_next;
  logic [4:0]      sector_no, sector_no_next;
  logic [1:0]      op_kind, op_kind_next;
  logic            pbw, pbw_next;
  logic            pdi, pdi_next;
  logic [5:0]      irq_flags, irq_flags_next;
  logic [IdxW-1:0] bidx, bidx_next;
  logic            busy, busy_next;
  logic            stale, stale_next;

  function automatic logic [11:0] advance(input logic [6:0] t, input logic [4:0] s);
    logic [5:0] s1;
    logic [7:0] t1;
    logic [6:0] t_o;
    s1 = {1'b0, s} + 6'd1;
    t_o = t;
    if (s1 > {1'b0, Spt}) begin
      s1 = 6'd1;
      t1 = {1'b0, t} + 8'd1;
      if (t1 > {1'b0, LastT}) t1 = 8'd1;
      t_o = t1[6:0];
    end
    return {t_o, s1[4:0]};
  endfunction

  function automatic logic [5:0] disk_end(input logic [6:0] t, input logic [4:0] s);
    return (s == Spt && t == LastT) ? IRQ_DISK_END : 6'd0;
  endfunction

  // Next state: command first, then the follow-up work on the result.
  always_comb begin
    logic [IdxW:0] inc;
    logic          found;
    logic [5:0]    v;
    phase_next     = phase;
    drive_sel_next = drive_sel;
    side_sel_next  = side_sel;
    track_no_next  = track_no;
    sector_no_next = sector_no;
    op_kind_next   = op_kind;
    pbw_next       = pbw;
    pdi_next       = pdi;
    irq_flags_next = irq_flags;
    bidx_next      = bidx;
    busy_next      = busy;
    stale_next     = stale;
    mreq           = '0;
    freq           = '0;
    res            = '0;
    inc            = {1'b0, bidx} + 1'b1;
    found          = 1'b0;
    v              = 6'd0;

    unique case (command)
      CMD_CPU_RD: begin
        if (phase == PH_IDLE) begin
          phase_next = PH_SECT_RD;
          res.reply  = 1'b1;
        end else if (phase == PH_BUF_RD) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = bidx;
          res.rd       = 1'b1;
          bidx_next    = inc[IdxW-1:0];
          if (inc >= SbIdx) begin
            bidx_next = '0;
            {track_no_next, sector_no_next} = advance(track_no, sector_no);
            phase_next = PH_IDLE;
          end
          irq_flags_next = '0;
        end else begin
          res.reply = 1'b1;
        end
      end
      CMD_CPU_WR: begin
        if (phase == PH_IDLE) begin
          phase_next = PH_WR_START;
          res.reply  = 1'b1;
        end else if (phase == PH_BUF_WR) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = bidx;
          mreq.wr_data = data[7:0];
          bidx_next    = inc[IdxW-1:0];
          if (inc >= SbIdx) begin
            bidx_next  = '0;
            phase_next = PH_SECT_WR;
          end
        end else begin
          if (phase == PH_SECT_WR) pbw_next = 1'b1;
          res.reply = 1'b1;
        end
      end
      CMD_CONTROL: begin
        if (phase == PH_IDLE) begin
          op_kind_next   = ctl_kind;
          drive_sel_next = {data[15], data[13]};
          side_sel_next  = data[12];
          track_no_next  = data[11:5];
          sector_no_next = data[4:0];
        end else begin
          res.reply = 1'b1;
        end
      end
      CMD_DETACH: begin
        if (phase == PH_IDLE) begin
          irq_flags_next = '0;
        end else begin
          if (phase == PH_BUF_RD) phase_next = PH_RD_CANCEL;
          else if (phase == PH_BUF_WR) phase_next = PH_WR_CANCEL;
          else if (phase == PH_SECT_WR) pdi_next = 1'b1;
          res.reply = 1'b1;
        end
      end
      CMD_RESET: begin
        found = 1'b1;
      end
      CMD_INT_ACK: begin
        for (int b = 0; b < 6; b++) begin
          if (irq_flags[b] && !res.int_spec[0] && res.int_spec == 5'd0) begin
            res.int_spec      = SPEC_TABLE[b];
            irq_flags_next[b] = 1'b0;
            if (b < 4) found = 1'b1;
          end
        end
      end
      CMD_RD_DONE, CMD_WR_DONE: begin
        if (busy) begin
          if (stale) begin
            busy_next  = 1'b0;
            stale_next = 1'b0;
          end else if (command == CMD_RD_DONE && phase == PH_SECT_RD) begin
            busy_next = 1'b0;
            if (!transfer_ok) begin
              v          = disk_end(track_no, sector_no) | IRQ_HW_ERR;
              phase_next = PH_IDLE;
            end else begin
              v          = disk_end(track_no, sector_no) | IRQ_READY;
              phase_next = PH_BUF_RD;
              bidx_next  = '0;
            end
            irq_flags_next = v;
            pdi_next       = 1'b0;
          end else if (command == CMD_WR_DONE && phase == PH_SECT_WR) begin
            busy_next = 1'b0;
            {track_no_next, sector_no_next} = advance(track_no, sector_no);
            phase_next = pbw ? PH_WR_START : PH_IDLE;
            pbw_next   = 1'b0;
            if (pdi) begin
              irq_flags_next = IRQ_READY;
              pdi_next       = 1'b0;
            end
          end
        end
      end
      CMD_DRV_STORE: begin
        if (data < SbData) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = data[IdxW-1:0];
          mreq.wr_data = drive_byte;
        end
      end
      CMD_DRV_FETCH: begin
        if (data < SbData) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = data[IdxW-1:0];
          res.rd       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Controller reset: from the reset command or an error acknowledge.
    if (found) begin
      drive_sel_next = '0;
      side_sel_next  = 1'b0;
      track_no_next  = 7'd1;
      sector_no_next = 5'd1;
      phase_next     = PH_IDLE;
      pbw_next       = 1'b0;
      pdi_next       = 1'b0;
      irq_flags_next = '0;
      bidx_next      = '0;
      if (busy) stale_next = 1'b1;
    end

    // Follow-up work when no drive transfer is in flight.
    if (!busy_next) begin
      unique case (phase_next)
        PH_SECT_RD: begin
          busy_next        = 1'b1;
          stale_next       = 1'b0;
          res.disk_request = REQ_READ;
        end
        PH_RD_CANCEL: begin
          phase_next     = PH_IDLE;
          bidx_next      = '0;
          {track_no_next, sector_no_next} = advance(track_no_next, sector_no_next);
          irq_flags_next = IRQ_READY;
          pdi_next       = 1'b0;
        end
        PH_WR_START: begin
          irq_flags_next = disk_end(track_no_next, sector_no_next) | IRQ_READY;
          pdi_next       = 1'b0;
          phase_next     = PH_BUF_WR;
          bidx_next      = '0;
        end
        PH_WR_CANCEL: begin
          freq.fill_start  = 1'b1;
          freq.fill_from   = bidx_next;
          bidx_next        = '0;
          pdi_next         = 1'b1;
          phase_next       = PH_SECT_WR;
          busy_next        = 1'b1;
          stale_next       = 1'b0;
          res.disk_request = REQ_WRITE;
        end
        PH_SECT_WR: begin
          busy_next        = 1'b1;
          stale_next       = 1'b0;
          res.disk_request = REQ_WRITE;
        end
        default: begin
        end
      endcase
    end

    if (res.disk_request != REQ_NONE) begin
      res.req_drive  = drive_sel_next;
      res.req_track  = track_no_next;
      res.req_sector = sector_no_next;
    end
    res.irq_pending = |irq_flags_next;

    if (!acc) begin
      mreq = '0;
      freq = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      drive_sel <= '0;
      side_sel  <= 1'b0;
      track_no  <= 7'd1;
      sector_no <= 5'd1;
      op_kind   <= '0;
      pbw       <= 1'b0;
      pdi       <= 1'b0;
      irq_flags <= '0;
      bidx      <= '0;
      busy      <= 1'b0;
      stale     <= 1'b0;
    end else if (acc) begin
      phase     <= phase_next;
      drive_sel <= drive_sel_next;
      side_sel  <= side_sel_next;
      track_no  <= track_no_next;
      sector_no <= sector_no_next;
      op_kind   <= op_kind_next;
      pbw       <= pbw_next;
      pdi       <= pdi_next;
      irq_flags <= irq_flags_next;
      bidx      <= bidx_next;
      busy      <= busy_next;
      stale     <= stale_next;
    end
  end

endmodule

// ===== design/floppy_sector_controller.sv =====
// ----------------------------------------------------------------------------
// floppy_sector_controller
// Sector controller between a CPU channel and a floppy drive.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event per item (CPU read/write/control/detach/reset/
//   no-op/interrupt acknowledge, drive completions, drive buffer store and
//   fetch). rsp returns exactly one result item per event, in order.
//   A result passes the read stage (buffer memory read) and then the output
//   register before it is valid on rsp.
//   Throughput: one item per cycle while req.ready is high; the control
//   registers update in the accept cycle, so the next item sees them at once.
//   A detach during a buffer write zero-fills the rest of the sector buffer
//   through the single write port, one byte a cycle, and req.ready stays low
//   until the sweep is done.
//   Reset (rst, synchronous): phase idle, address drive 0 track 1 sector 1,
//   interrupts clear. Buffer contents are undefined until written.
//   When rsp stalls, one result waits in the output register and one in the
//   read stage; apart from a zero-fill, req.ready drops only when both are full.
// ----------------------------------------------------------------------------
module floppy_sector_controller
  import fsc_pkg::*;
#(
  parameter int SECTORS_PER_TRACK = 26,
  parameter int LAST_TRACK        = 76,
  parameter int SECTOR_BYTES      = 128
) (
  input logic      clk,
  input logic      rst,
  fsc_in_if.sink   req,
  fsc_out_if.source rsp
);

  mem_req_t   mreq;
  fill_req_t  freq;
  result_t    res;
  logic [7:0] rdata;
  logic       fill_busy;
  logic       acc;

  // Read stage: result waiting for its buffer byte.
  logic    p_valid;
  result_t p_res;
  // Output register.
  logic    o_valid;
  result_t o_res;
  logic [7:0] o_byte;
  logic    p_move;

  assign p_move    = p_valid && (!o_valid || rsp.ready);
  assign req.ready = !fill_busy && (!p_valid || !o_valid || rsp.ready);
  assign acc       = req.valid && req.ready;

  fsc_ctrl #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .LAST_TRACK        (LAST_TRACK),
    .SECTOR_BYTES      (SECTOR_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .command     (req.command),
    .data        (req.data),
    .drive_byte  (req.drive_byte),
    .ctl_kind    (req.ctl_kind),
    .transfer_ok (req.transfer_ok),
    .mreq        (mreq),
    .freq        (freq),
    .res         (res)
  );

  fsc_buffer #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_buffer (
    .clk       (clk),
    .rst       (rst),
    .mreq      (mreq),
    .freq      (freq),
    .rdata     (rdata),
    .fill_busy (fill_busy)
  );

  // Advance the read stage; hold it while the output register is full and rsp is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (acc) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_res <= res;
    end
  end

  // Output register: drop on take, load from the read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (p_move) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_res  <= p_res;
      o_byte <= p_res.rd ? rdata : 8'h00;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.reply        = o_res.reply;
  assign rsp.read_byte    = o_byte;
  assign rsp.int_spec     = o_res.int_spec;
  assign rsp.irq_pending  = o_res.irq_pending;
  assign rsp.disk_request = o_res.disk_request;
  assign rsp.req_drive    = o_res.req_drive;
  assign rsp.req_track    = o_res.req_track;
  assign rsp.req_sector   = o_res.req_sector;

endmodule

// ===== tb/floppy_sector_controller_tb.sv =====
// ----------------------------------------------------------------------------
// floppy_sector_controller_tb
// Self-checking bench for the floppy sector controller. Drives one event per
// item with random gaps, stalls the result channel at random, and compares
// every result item field by field against a cycle-free behavioral predictor.
// ----------------------------------------------------------------------------
module floppy_sector_controller_tb;
  import fsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPT      = 26;
  localparam int LAST_TRK = 76;
  localparam int SECT_B   = 128;
  localparam int N_ITEMS  = 800;

  // One expected result item.
  typedef struct {
    logic       reply;
    logic [7:0] read_byte;
    logic [4:0] int_spec;
    logic       irq_pending;
    logic [1:0] disk_request;
    logic [1:0] req_drive;
    logic [6:0] req_track;
    logic [4:0] req_sector;
  } ctl_result_t;

  // Controller shadow: tracks state on each accepted item and queues the
  // result item the controller must return for it.
  class ctl_scoreboard;
    phase_t      ph;
    logic [1:0]  drv;
    logic        side;
    logic [6:0]  trk;
    logic [4:0]  sec;
    logic [1:0]  op_kind;
    logic        wr_pending, detach_pending, busy, stale;
    logic [5:0]  irq;
    int          idx;
    logic [7:0]  sect_buf [SECT_B];
    bit          written [SECT_B];
    ctl_result_t pending_results [$];
    ctl_result_t cur;
    int          mismatches;

    function new();
      foreach (written[i]) written[i] = 0;
      busy = 0;
      stale = 0;
      op_kind = 0;
      mismatches = 0;
      reset_ctl();
    endfunction

    function void set_addr(logic [15:0] a);
      drv  = {a[15], a[13]};
      side = a[12];
      trk  = a[11:5];
      sec  = a[4:0];
    endfunction

    function void reset_ctl();
      set_addr(16'h0021);
      ph = PH_IDLE;
      wr_pending = 0;
      detach_pending = 0;
      irq = '0;
      idx = 0;
      if (busy) stale = 1;
    endfunction

    function void step_addr();
      if (int'(sec) + 1 > SPT) begin
        sec = 5'd1;
        trk = (int'(trk) + 1 > LAST_TRK) ? 7'd1 : trk + 7'd1;
      end else begin
        sec = sec + 5'd1;
      end
    endfunction

    function logic [5:0] at_end();
      return (sec == SPT && trk == LAST_TRK) ? IRQ_DISK_END : 6'd0;
    endfunction

    function void raise(logic [5:0] v);
      if (v == 0) return;
      irq = v;
      detach_pending = 0;
    endfunction

    function void issue(disk_req_t k);
      busy = 1;
      stale = 0;
      cur.disk_request = k;
      cur.req_drive = drv;
      cur.req_track = trk;
      cur.req_sector = sec;
    endfunction

    function void put(int i, logic [7:0] b);
      sect_buf[i] = b;
      written[i] = 1;
    endfunction

    // Follow-up work done at the end of the step while the drive is free.
    function void follow_up();
      logic [5:0] v;
      v = '0;
      if (busy) return;
      case (ph)
        PH_SECT_RD: issue(REQ_READ);
        PH_RD_CANCEL: begin
          v = IRQ_READY;
          ph = PH_IDLE;
          idx = 0;
          step_addr();
        end
        PH_WR_START: begin
          v = at_end() | IRQ_READY;
          ph = PH_BUF_WR;
          idx = 0;
        end
        PH_WR_CANCEL: begin
          for (int i = idx; i < SECT_B; i++) put(i, 8'd0);
          idx = 0;
          detach_pending = 1;
          ph = PH_SECT_WR;
          issue(REQ_WRITE);
        end
        PH_SECT_WR: issue(REQ_WRITE);
        default: ;
      endcase
      raise(v);
    endfunction

    // Note an accepted input item and queue its expected result item.
    function void note(logic [3:0] cmd, logic [15:0] d, logic [7:0] db, logic [1:0] k,
                       logic ok);
      logic [5:0] v;
      cur = '{default: '0};
      case (cmd)
        CMD_CPU_RD: begin
          if (ph == PH_IDLE) begin
            ph = PH_SECT_RD;
            cur.reply = 1;
          end else if (ph == PH_BUF_RD) begin
            cur.read_byte = sect_buf[idx];
            idx++;
            if (idx >= SECT_B) begin
              idx = 0;
              step_addr();
              ph = PH_IDLE;
            end
            irq = '0;
          end else begin
            cur.reply = 1;
          end
        end
        CMD_CPU_WR: begin
          if (ph == PH_IDLE) begin
            ph = PH_WR_START;
            cur.reply = 1;
          end else if (ph == PH_BUF_WR) begin
            put(idx, d[7:0]);
            idx++;
            if (idx >= SECT_B) begin
              idx = 0;
              ph = PH_SECT_WR;
            end
          end else begin
            if (ph == PH_SECT_WR) wr_pending = 1;
            cur.reply = 1;
          end
        end
        CMD_CONTROL: begin
          if (ph == PH_IDLE) begin
            op_kind = k;
            set_addr(d);
          end else begin
            cur.reply = 1;
          end
        end
        CMD_DETACH: begin
          if (ph == PH_IDLE) begin
            irq = '0;
          end else begin
            if (ph == PH_BUF_RD) ph = PH_RD_CANCEL;
            else if (ph == PH_BUF_WR) ph = PH_WR_CANCEL;
            else if (ph == PH_SECT_WR) detach_pending = 1;
            cur.reply = 1;
          end
        end
        CMD_RESET: reset_ctl();
        CMD_INT_ACK: begin
          for (int b = 0; b < 6; b++) begin
            if (irq[b]) begin
              cur.int_spec = SPEC_TABLE[b];
              irq[b] = 0;
              if (b < 4) reset_ctl();
              break;
            end
          end
        end
        CMD_RD_DONE, CMD_WR_DONE: begin
          if (busy) begin
            if (stale) begin
              busy = 0;
              stale = 0;
            end else if (cmd == CMD_RD_DONE && ph == PH_SECT_RD) begin
              busy = 0;
              v = at_end();
              if (!ok) begin
                v |= IRQ_HW_ERR;
                ph = PH_IDLE;
              end else begin
                v |= IRQ_READY;
                ph = PH_BUF_RD;
                idx = 0;
              end
              raise(v);
            end else if (cmd == CMD_WR_DONE && ph == PH_SECT_WR) begin
              busy = 0;
              v = '0;
              step_addr();
              if (detach_pending) v |= IRQ_READY;
              if (wr_pending) begin
                ph = PH_WR_START;
                wr_pending = 0;
              end else begin
                ph = PH_IDLE;
              end
              raise(v);
            end
          end
        end
        CMD_DRV_STORE: if (d < SECT_B) put(d, db);
        CMD_DRV_FETCH: if (d < SECT_B) cur.read_byte = sect_buf[d];
        default: ;
      endcase
      follow_up();
      cur.irq_pending = (irq != 0);
      pending_results.push_back(cur);
    endfunction

    function void fail(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, what);
    endfunction

    // Check one accepted result item against the oldest expectation.
    function void check(ctl_result_t got);
      ctl_result_t exp;
      if (pending_results.size() == 0) begin
        fail("result item with no expectation waiting");
        return;
      end
      exp = pending_results.pop_front();
      if (got.reply !== exp.reply)
        fail($sformatf("reply exp %0d got %0d", exp.reply, got.reply));
      if (got.read_byte !== exp.read_byte)
        fail($sformatf("read_byte exp %0h got %0h", exp.read_byte, got.read_byte));
      if (got.int_spec !== exp.int_spec)
        fail($sformatf("int_spec exp %0h got %0h", exp.int_spec, got.int_spec));
      if (got.irq_pending !== exp.irq_pending)
        fail($sformatf("irq_pending exp %0d got %0d", exp.irq_pending, got.irq_pending));
      if (got.disk_request !== exp.disk_request)
        fail($sformatf("disk_request exp %0d got %0d", exp.disk_request, got.disk_request));
      if (got.req_drive !== exp.req_drive)
        fail($sformatf("req_drive exp %0d got %0d", exp.req_drive, got.req_drive));
      if (got.req_track !== exp.req_track)
        fail($sformatf("req_track exp %0d got %0d", exp.req_track, got.req_track));
      if (got.req_sector !== exp.req_sector)
        fail($sformatf("req_sector exp %0d got %0d", exp.req_sector, got.req_sector));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;

  fsc_in_if  in_ch();
  fsc_out_if out_ch();

  floppy_sector_controller #(
    .SECTORS_PER_TRACK(SPT),
    .LAST_TRACK(LAST_TRK),
    .SECTOR_BYTES(SECT_B)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(in_ch),
    .rsp(out_ch)
  );

  always #1 clk = ~clk;

  ctl_scoreboard sb = new();
  bit            calm;      // when set, neither side idles
  int            stall_left;

  // Drive one item: idle for a random gap, then hold it until accepted.
  task automatic send(cmd_t cmd, logic [15:0] d = 16'd0, logic [7:0] db = 8'd0,
                      logic [1:0] k = 2'd0, logic ok = 1'b1);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1;
    in_ch.command = cmd;
    in_ch.data = d;
    in_ch.drive_byte = db;
    in_ch.ctl_kind = k;
    in_ch.transfer_ok = ok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note(cmd, d, db, k, ok);
  endtask

  // Control word for a mostly reachable address; sometimes fully random bits.
  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    a = 16'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      a[11:5] = 7'($urandom_range(1, LAST_TRK));
      a[4:0] = 5'($urandom_range(1, SPT));
      if ($urandom_range(0, 5) == 0) begin
        a[11:5] = 7'(LAST_TRK);
        a[4:0] = 5'(SPT - $urandom_range(0, 2));
      end
    end
    return a;
  endfunction

  // One random event, weighted toward the commands that move the phases on.
  task automatic send_random();
    int          r;
    cmd_t        cmd;
    logic [15:0] d;
    d = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 22) cmd = CMD_CPU_RD;
    else if (r < 44) cmd = CMD_CPU_WR;
    else if (r < 54) cmd = CMD_RD_DONE;
    else if (r < 62) cmd = CMD_WR_DONE;
    else if (r < 69) cmd = CMD_CONTROL;
    else if (r < 75) cmd = CMD_DETACH;
    else if (r < 83) cmd = CMD_INT_ACK;
    else if (r < 88) cmd = CMD_DRV_STORE;
    else if (r < 93) cmd = CMD_DRV_FETCH;
    else if (r < 95) cmd = CMD_RESET;
    else if (r < 97) cmd = CMD_NOP;
    else cmd = cmd_t'($urandom_range(11, 15));
    if (cmd == CMD_CONTROL) d = pick_addr();
    if ((cmd == CMD_DRV_STORE || cmd == CMD_DRV_FETCH) && $urandom_range(0, 7) != 0)
      d = 16'($urandom_range(0, SECT_B - 1));
    // Never read a buffer entry that nothing has written: store it instead.
    if (cmd == CMD_CPU_RD && sb.ph == PH_BUF_RD && !sb.written[sb.idx]) begin
      cmd = CMD_DRV_STORE;
      d = 16'(sb.idx);
    end
    if (cmd == CMD_DRV_FETCH && d < SECT_B && !sb.written[d]) cmd = CMD_DRV_STORE;
    send(cmd, d, 8'($urandom), 2'($urandom), $urandom_range(0, 5) != 0);
  endtask

  // Result side: draw a stall per item, sample at the rising edge.
  initial begin
    out_ch.ready = 0;
    stall_left = 0;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check('{out_ch.reply, out_ch.read_byte, out_ch.int_spec, out_ch.irq_pending,
                 out_ch.disk_request, out_ch.req_drive, out_ch.req_track,
                 out_ch.req_sector});
      stall_left <= calm ? 0 : $urandom_range(0, 10);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int sent;
    in_ch.valid = 0;
    in_ch.command = CMD_NOP;
    in_ch.data = '0;
    in_ch.drive_byte = '0;
    in_ch.ctl_kind = '0;
    in_ch.transfer_ok = 0;
    calm = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: field extremes, each command, disk end, cancels, stale and
    // spurious completions, error acknowledge.
    send(CMD_NOP);
    send(CMD_DRV_FETCH, 16'hFFFF);
    send(CMD_DRV_STORE, 16'hFFFF, 8'hFF);
    send(CMD_CONTROL, 16'hFFFF, 8'h00, 2'd3);
    send(CMD_INT_ACK);
    send(CMD_DETACH);
    send(cmd_t'(4'd15), 16'hFFFF, 8'hFF, 2'd3, 1'b1);
    send(CMD_CONTROL, {3'b101, 1'b1, 7'(LAST_TRK), 5'(SPT)}, 8'h00, 2'd1);
    send(CMD_CPU_WR);                       // opens buffer write, disk end flagged
    send(CMD_INT_ACK);
    send(CMD_CPU_WR, 16'hFFFF);
    send(CMD_DETACH);                       // zero-fill rest, sector write issued
    send(CMD_CPU_WR);                       // write pending during sector write
    send(CMD_WR_DONE, 16'h0, 8'h0, 2'd0, 1'b0);
    send(CMD_DETACH);                       // cancel the restarted buffer write
    send(CMD_WR_DONE);
    send(CMD_INT_ACK);
    send(CMD_CPU_RD);
    send(CMD_RD_DONE, 16'h0, 8'h0, 2'd0, 1'b0);
    send(CMD_INT_ACK);                      // hardware error resets the controller
    send(CMD_CPU_RD);
    send(CMD_RESET);                        // leaves the read in flight stale
    send(CMD_RD_DONE);
    send(CMD_WR_DONE);
    send(CMD_DRV_STORE, 16'd127, 8'h5A);
    send(CMD_DRV_FETCH, 16'd127);

    // Random: single events plus runs of full-sector reads or writes, with
    // stretches where neither side idles.
    sent = 0;
    while (sent < N_ITEMS) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          if (sb.ph == PH_IDLE) send(CMD_CONTROL, pick_addr(), 8'h0, 2'($urandom));
          if (sb.ph == PH_BUF_RD && !sb.written[sb.idx])
            send(CMD_DRV_STORE, 16'(sb.idx), 8'($urandom));
          send(CMD_CPU_RD);
          send(CMD_RD_DONE);
          for (int i = 0; i < SECT_B + 2; i++) begin
            if (sb.ph == PH_BUF_RD && !sb.written[sb.idx])
              send(CMD_DRV_STORE, 16'(sb.idx), 8'($urandom));
            send(CMD_CPU_RD);
          end
        end else begin
          send(CMD_CPU_WR, 16'($urandom));
          for (int i = 0; i < SECT_B + 2; i++) send(CMD_CPU_WR, 16'($urandom));
          send(CMD_WR_DONE);
        end
        sent += SECT_B + 4;
      end else begin
        send_random();
        sent++;
      end
    end
    @(negedge clk);
    in_ch.valid = 0;
    calm = 0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
